// ===== rtl/core/tbsc_pkg.sv =====
`default_nettype none

package tbsc_pkg;

  // Request codes carried in tuser of the input channel
  localparam logic [1:0] REQ_LOCK   = 2'd0;
  localparam logic [1:0] REQ_UNLOCK = 2'd1;
  localparam logic [1:0] REQ_CYCLE  = 2'd2;

  // Slot numbers at reset
  localparam logic [1:0] SLOT_FRONT_RST  = 2'd0;
  localparam logic [1:0] SLOT_MIDDLE_RST = 2'd1;
  localparam logic [1:0] SLOT_BACK_RST   = 2'd2;
  localparam logic [1:0] SLOT_COUNT      = 2'd3;

  // Frame index meaning "no frame"
  localparam logic signed [31:0] NO_FRAME = -32'sd1;

  // Default consumer lock limit
  localparam int MaxLocksDefault = 255;

  // Payload widths
  localparam int InDataWidth  = 32;
  localparam int InUserWidth  = 2;
  localparam int OutDataWidth = 48;

  // One result item
  typedef struct packed {
    logic [7:0]         locks_held;
    logic               error;
    logic signed [31:0] ready_frame_index;
    logic               ready_res;
    logic [1:0]         slot;
  } tbsc_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/triple_buffer_swap_control.sv =====
// Triple-buffer swap control with a consumer lock.
// Input channel (s_*): one request item per handshake; tuser carries the request
// kind (lock, unlock, cycle) and tdata the producer's frame index for a cycle.
// Output channel (m_*): exactly one result item per request: slot to use, ready
// flag, frame index of the front slot, error flag and locks held afterward.
// Each item passes the input register and then the result register, where its
// result is registered and held until the receiver takes it.
// Throughput: one item per cycle while m_tready stays high; the slot roles, per-role
// frame indices and lock count are updated by a single pass of compare-and-swap
// logic as an item moves into the result register.
// Reset: front, middle, back slots are 0, 1, 2, lock count is 0, and every slot
// holds no frame (-1). Both pipeline registers are emptied.
// Stall: when m_tready is low the result holds; the input register still takes
// one more item, after which s_tready drops until the result is taken.
`default_nettype none

module triple_buffer_swap_control
  import tbsc_pkg::*;
#(
  parameter int MAX_LOCKS = MaxLocksDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [InDataWidth-1:0]  s_tdata,  // [31:0] produced_frame_index
  input  wire logic [InUserWidth-1:0]  s_tuser,  // [1:0] req_type
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // [1:0] slot, [2] ready_res, [34:3] ready_frame_index, [35] error,
  // [43:36] locks_held, [47:44] zero
  output logic [OutDataWidth-1:0]      m_tdata
);

  logic               in_valid;
  logic [1:0]         in_req;
  logic signed [31:0] in_idx;
  logic               advance;
  tbsc_res_t          res_comb;
  tbsc_res_t          res;

  // Item moves on when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= s_tuser[1:0];
      in_idx <= s_tdata[31:0];
    end
  end

  tbsc_state #(
    .MAX_LOCKS(MAX_LOCKS)
  ) u_state (
    .clk                  (clk),
    .rst                  (rst),
    .advance              (advance),
    .req_type             (in_req),
    .produced_frame_index (in_idx),
    .res                  (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {4'b0000, res.locks_held, res.error, res.ready_frame_index,
                    res.ready_res, res.slot};

  // A result waiting on the receiver is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result lost");

  // An item in the input register moves on at once when the result register is empty
  a_input_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && !m_tvalid |-> advance)
    else $error("input item blocked with empty output");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while empty");

endmodule

`default_nettype wire

// ===== rtl/core/tbsc_state.sv =====
`default_nettype none

module tbsc_state
  import tbsc_pkg::*;
#(
  parameter int MAX_LOCKS = MaxLocksDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] produced_frame_index,
  output tbsc_res_t               res
);

  // Count is 8 bits wide, so the limit saturates at 255
  localparam logic [7:0] LockLimit = (MAX_LOCKS > 255) ? 8'd255 : 8'(MAX_LOCKS);

  // Slot roles and the frame index held by the slot in each role
  logic [1:0]         front_slot, front_slot_next;
  logic [1:0]         middle_slot, middle_slot_next;
  logic [1:0]         back_slot, back_slot_next;
  logic [7:0]         lock_count, lock_count_next;
  logic signed [31:0] front_idx, front_idx_next;
  logic signed [31:0] middle_idx, middle_idx_next;
  logic signed [31:0] back_idx, back_idx_next;

  // Work out the next roles and the result of this item
  always_comb begin
    front_slot_next  = front_slot;
    middle_slot_next = middle_slot;
    back_slot_next   = back_slot;
    lock_count_next  = lock_count;
    front_idx_next   = front_idx;
    middle_idx_next  = middle_idx;
    back_idx_next    = back_idx;
    res.ready_res    = 1'b0;
    res.error        = 1'b0;
    res.slot         = front_slot;
    case (req_type)
      REQ_LOCK: begin
        if (lock_count >= LockLimit) begin
          res.error = 1'b1;
        end else begin
          lock_count_next = lock_count + 8'd1;
        end
      end
      REQ_UNLOCK: begin
        if (lock_count == 8'd0) begin
          res.error = 1'b1;
        end else begin
          lock_count_next = lock_count - 8'd1;
          // Last lock released: promote a newer middle frame
          if (lock_count == 8'd1 && middle_idx != NO_FRAME && middle_idx > front_idx) begin
            front_slot_next  = middle_slot;
            middle_slot_next = front_slot;
            front_idx_next   = middle_idx;
            middle_idx_next  = front_idx;
            res.slot         = middle_slot;
            res.ready_res    = 1'b1;
          end
        end
      end
      REQ_CYCLE: begin
        if (lock_count != 8'd0) begin
          // Front busy: park the new frame in the middle
          back_slot_next   = middle_slot;
          middle_slot_next = back_slot;
          back_idx_next    = middle_idx;
          middle_idx_next  = produced_frame_index;
          res.slot         = middle_slot;
        end else begin
          // Front free: new frame goes straight to the front
          front_slot_next = back_slot;
          back_slot_next  = front_slot;
          front_idx_next  = produced_frame_index;
          back_idx_next   = front_idx;
          res.slot        = front_slot;
          res.ready_res   = (produced_frame_index != NO_FRAME);
        end
      end
      default: begin
        res.error = 1'b1;
      end
    endcase
    res.ready_frame_index = front_idx_next;
    res.locks_held        = lock_count_next;
  end

  // Commit the state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      front_slot  <= SLOT_FRONT_RST;
      middle_slot <= SLOT_MIDDLE_RST;
      back_slot   <= SLOT_BACK_RST;
      lock_count  <= 8'd0;
      front_idx   <= NO_FRAME;
      middle_idx  <= NO_FRAME;
      back_idx    <= NO_FRAME;
    end else if (advance) begin
      front_slot  <= front_slot_next;
      middle_slot <= middle_slot_next;
      back_slot   <= back_slot_next;
      lock_count  <= lock_count_next;
      front_idx   <= front_idx_next;
      middle_idx  <= middle_idx_next;
      back_idx    <= back_idx_next;
    end
  end

  // The three roles always name three different slots
  a_roles_distinct: assert property (@(posedge clk) disable iff (rst)
    front_slot != middle_slot && front_slot != back_slot && middle_slot != back_slot)
    else $error("slot roles overlap");

  a_slots_in_range: assert property (@(posedge clk) disable iff (rst)
    front_slot < SLOT_COUNT && middle_slot < SLOT_COUNT && back_slot < SLOT_COUNT)
    else $error("slot number out of range");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    lock_count <= LockLimit)
    else $error("lock count above limit");

  a_ready_has_frame: assert property (@(posedge clk) disable iff (rst)
    res.ready_res |-> res.ready_frame_index != NO_FRAME)
    else $error("ready raised without a front frame");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(front_slot) && $stable(lock_count) && $stable(front_idx))
    else $error("state changed without an item");

endmodule

`default_nettype wire
